// File: design/clnbs_pkg.sv
// Shared types and the control store for the character LCD nibble bus sequencer.
// Depends on nothing; used by char_lcd_nibble_bus_sequencer, lcd_snapshot_checker and tb_top.
package clnbs_pkg;

    localparam int unsigned ROM_DEPTH   = 43;
    localparam int unsigned PC_W        = 6;
    localparam logic [PC_W-1:0] INIT_ENTRY = 6'd0;
    localparam logic [PC_W-1:0] BYTE_ENTRY = 6'd38;
    localparam logic [PC_W-1:0] PC_LAST    = 6'd42;

    localparam logic [12:0] WAIT_LONG  = 13'd5000;
    localparam logic [12:0] WAIT_SHORT = 13'd200;

    localparam logic [7:0] CMD_CLEAR = 8'h01;

    typedef enum logic [1:0] {
        OP_INIT  = 2'd0,
        OP_CHAR  = 2'd1,
        OP_CLEAR = 2'd2,
        OP_GOTO  = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        NS_CONST = 2'd0,
        NS_HI    = 2'd1,
        NS_LO    = 2'd2
    } t_nsel;

    typedef enum logic [1:0] {
        W_ZERO  = 2'd0,
        W_PULSE = 2'd1,
        W_SHORT = 2'd2,
        W_LONG  = 2'd3
    } t_wsel;

    typedef struct packed {
        t_nsel      nsel;
        logic [3:0] nib;
        logic       e;
        t_wsel      wsel;
        logic       last;
    } t_ctrl;

    function automatic t_ctrl cw(t_nsel nsel, logic [3:0] nib, logic e, t_wsel wsel,
                                 logic last);
        t_ctrl c;
        c.nsel = nsel;
        c.nib  = nib;
        c.e    = e;
        c.wsel = wsel;
        c.last = last;
        return c;
    endfunction

    // Steps 0 to 37 form the power-on program, steps 38 to 42 send the byte register.
    function automatic t_ctrl rom_word(logic [PC_W-1:0] pc);
        t_ctrl c;
        unique case (pc)
            6'd0:    c = cw(NS_CONST, 4'h0, 1'b0, W_LONG,  1'b0);
            6'd1:    c = cw(NS_CONST, 4'h3, 1'b0, W_ZERO,  1'b0);
            6'd2:    c = cw(NS_CONST, 4'h3, 1'b1, W_PULSE, 1'b0);
            6'd3:    c = cw(NS_CONST, 4'h3, 1'b0, W_LONG,  1'b0);
            6'd4:    c = cw(NS_CONST, 4'h3, 1'b0, W_ZERO,  1'b0);
            6'd5:    c = cw(NS_CONST, 4'h3, 1'b1, W_PULSE, 1'b0);
            6'd6:    c = cw(NS_CONST, 4'h3, 1'b0, W_SHORT, 1'b0);
            6'd7:    c = cw(NS_CONST, 4'h3, 1'b0, W_ZERO,  1'b0);
            6'd8:    c = cw(NS_CONST, 4'h3, 1'b1, W_PULSE, 1'b0);
            6'd9:    c = cw(NS_CONST, 4'h3, 1'b0, W_SHORT, 1'b0);
            6'd10:   c = cw(NS_CONST, 4'h2, 1'b0, W_ZERO,  1'b0);
            6'd11:   c = cw(NS_CONST, 4'h2, 1'b1, W_PULSE, 1'b0);
            6'd12:   c = cw(NS_CONST, 4'h2, 1'b0, W_LONG,  1'b0);
            6'd13:   c = cw(NS_CONST, 4'h2, 1'b0, W_ZERO,  1'b0);
            6'd14:   c = cw(NS_CONST, 4'h2, 1'b1, W_PULSE, 1'b0);
            6'd15:   c = cw(NS_CONST, 4'h8, 1'b0, W_ZERO,  1'b0);
            6'd16:   c = cw(NS_CONST, 4'h8, 1'b1, W_PULSE, 1'b0);
            6'd17:   c = cw(NS_CONST, 4'h8, 1'b0, W_ZERO,  1'b0);
            6'd18:   c = cw(NS_CONST, 4'h0, 1'b0, W_ZERO,  1'b0);
            6'd19:   c = cw(NS_CONST, 4'h0, 1'b1, W_PULSE, 1'b0);
            6'd20:   c = cw(NS_CONST, 4'h8, 1'b0, W_ZERO,  1'b0);
            6'd21:   c = cw(NS_CONST, 4'h8, 1'b1, W_PULSE, 1'b0);
            6'd22:   c = cw(NS_CONST, 4'h8, 1'b0, W_ZERO,  1'b0);
            6'd23:   c = cw(NS_CONST, 4'h0, 1'b0, W_ZERO,  1'b0);
            6'd24:   c = cw(NS_CONST, 4'h0, 1'b1, W_PULSE, 1'b0);
            6'd25:   c = cw(NS_CONST, 4'h1, 1'b0, W_ZERO,  1'b0);
            6'd26:   c = cw(NS_CONST, 4'h1, 1'b1, W_PULSE, 1'b0);
            6'd27:   c = cw(NS_CONST, 4'h1, 1'b0, W_ZERO,  1'b0);
            6'd28:   c = cw(NS_CONST, 4'h0, 1'b0, W_ZERO,  1'b0);
            6'd29:   c = cw(NS_CONST, 4'h0, 1'b1, W_PULSE, 1'b0);
            6'd30:   c = cw(NS_CONST, 4'h6, 1'b0, W_ZERO,  1'b0);
            6'd31:   c = cw(NS_CONST, 4'h6, 1'b1, W_PULSE, 1'b0);
            6'd32:   c = cw(NS_CONST, 4'h6, 1'b0, W_ZERO,  1'b0);
            6'd33:   c = cw(NS_CONST, 4'h0, 1'b0, W_ZERO,  1'b0);
            6'd34:   c = cw(NS_CONST, 4'h0, 1'b1, W_PULSE, 1'b0);
            6'd35:   c = cw(NS_CONST, 4'hC, 1'b0, W_ZERO,  1'b0);
            6'd36:   c = cw(NS_CONST, 4'hC, 1'b1, W_PULSE, 1'b0);
            6'd37:   c = cw(NS_CONST, 4'hC, 1'b0, W_ZERO,  1'b1);
            6'd38:   c = cw(NS_HI,    4'h0, 1'b0, W_ZERO,  1'b0);
            6'd39:   c = cw(NS_HI,    4'h0, 1'b1, W_PULSE, 1'b0);
            6'd40:   c = cw(NS_LO,    4'h0, 1'b0, W_ZERO,  1'b0);
            6'd41:   c = cw(NS_LO,    4'h0, 1'b1, W_PULSE, 1'b0);
            6'd42:   c = cw(NS_LO,    4'h0, 1'b0, W_ZERO,  1'b1);
            default: c = cw(NS_CONST, 4'h0, 1'b0, W_ZERO,  1'b1);
        endcase
        return c;
    endfunction

endpackage

// File: design/char_lcd_nibble_bus_sequencer.sv
// Top level of the character LCD nibble bus sequencer: a step counter walks a
// control store and a small datapath turns each control word into one pin snapshot.
// Depends on clnbs_pkg for the control store and its types.
// A request is loaded into the step counter and byte register, and the output registers
// then capture the snapshot of each step. Throughput: one snapshot per cycle while the sink
// is ready; init gives 38 snapshots, the others 5, and no request is taken while busy.
// The step counter issues one control word per cycle while the sink is ready; it is the limit on rate.
// Reset (synchronous, active low) clears the busy flag and the output valid flag.
module char_lcd_nibble_bus_sequencer import clnbs_pkg::*; #(
    parameter int unsigned PULSE_US = 1
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_op,
    input  logic [7:0]  i_char_code,
    input  logic [5:0]  i_column,
    input  logic        i_row,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_reg_sel,
    output logic        o_enable,
    output logic        o_read_write,
    output logic [3:0]  o_data_nibble,
    output logic [12:0] o_wait_us,
    output logic        o_last
);

    logic            r_busy;
    logic [PC_W-1:0] r_pc;
    logic [7:0]      r_byte;
    logic            r_rs;
    logic            r_out_valid;
    logic            r_reg_sel;
    logic            r_enable;
    logic [3:0]      r_nib;
    logic [12:0]     r_wait;
    logic            r_last;

    t_ctrl      w_ctrl;
    logic       w_accept;
    logic       w_step;
    t_op        w_op;
    logic [7:0] n_byte;
    logic [3:0] n_nib;
    logic [12:0] n_wait;

    assign w_ctrl   = rom_word(r_pc);
    assign w_op     = t_op'(i_op);
    assign w_accept = i_in_valid && !r_busy;
    assign w_step   = r_busy && (!r_out_valid || i_out_ready);

    always_comb begin
        unique case (w_op)
            OP_CHAR:  n_byte = i_char_code;
            OP_CLEAR: n_byte = CMD_CLEAR;
            OP_GOTO:  n_byte = {1'b1, i_row, i_column};
            default:  n_byte = 8'h00;
        endcase
    end

    always_comb begin
        unique case (w_ctrl.nsel)
            NS_HI:   n_nib = r_byte[7:4];
            NS_LO:   n_nib = r_byte[3:0];
            default: n_nib = w_ctrl.nib;
        endcase
    end

    always_comb begin
        unique case (w_ctrl.wsel)
            W_PULSE: n_wait = 13'(PULSE_US);
            W_SHORT: n_wait = WAIT_SHORT;
            W_LONG:  n_wait = WAIT_LONG;
            default: n_wait = 13'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_busy <= 1'b1;
                r_pc   <= (w_op == OP_INIT) ? INIT_ENTRY : BYTE_ENTRY;
                r_byte <= n_byte;
                r_rs   <= (w_op == OP_CHAR);
            end else if (w_step) begin
                r_pc <= r_pc + 1'b1;
                if (w_ctrl.last) begin
                    r_busy <= 1'b0;
                end
            end
            if (w_step) begin
                r_out_valid <= 1'b1;
                r_reg_sel   <= r_rs;
                r_enable    <= w_ctrl.e;
                r_nib       <= n_nib;
                r_wait      <= n_wait;
                r_last      <= w_ctrl.last;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_in_ready    = !r_busy;
    assign o_out_valid   = r_out_valid;
    assign o_reg_sel     = r_reg_sel;
    assign o_enable      = r_enable;
    assign o_read_write  = 1'b0;
    assign o_data_nibble = r_nib;
    assign o_wait_us     = r_wait;
    assign o_last        = r_last;

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> r_busy && (r_pc == INIT_ENTRY || r_pc == BYTE_ENTRY))
        else $error("request accepted without starting a program");

    a_last_stops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_step && w_ctrl.last |=> !r_busy)
        else $error("program did not stop after its final step");

    a_pc_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> r_pc <= PC_LAST)
        else $error("step counter ran past the control store");

    a_pulse_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_enable |-> o_wait_us == 13'(PULSE_US) && !o_last)
        else $error("enable pulse with wrong hold time");

endmodule

// File: tb/lcd_snapshot_checker.sv
`timescale 1ns / 100ps
// Checker for the character LCD nibble bus sequencer: predicts the pin snapshots of each
// accepted request and compares them, field by field, with the snapshots the block emits.
// Depends on clnbs_pkg for the request codes and the wait constants.
module lcd_snapshot_checker import clnbs_pkg::*; #(
    parameter int unsigned PULSE_US = 1
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_req_valid,
    input  logic        i_req_ready,
    input  logic [1:0]  i_op,
    input  logic [7:0]  i_char_code,
    input  logic [5:0]  i_column,
    input  logic        i_row,
    input  logic        i_snap_valid,
    input  logic        i_snap_ready,
    input  logic        i_reg_sel,
    input  logic        i_enable,
    input  logic        i_read_write,
    input  logic [3:0]  i_data_nibble,
    input  logic [12:0] i_wait_us,
    input  logic        i_last,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_snapshots_checked
);

    localparam logic [7:0]  CMD_FUNC_4BIT_2LINE = 8'h28;
    localparam logic [7:0]  CMD_DISPLAY_OFF     = 8'h08;
    localparam logic [7:0]  CMD_ENTRY_INCREMENT = 8'h06;
    localparam logic [7:0]  CMD_DISPLAY_ON      = 8'h0C;
    localparam logic [7:0]  LINE1_BASE          = 8'h80;
    localparam logic [7:0]  LINE2_BASE          = 8'hC0;
    localparam logic [3:0]  NIB_WAKE            = 4'h3;
    localparam logic [3:0]  NIB_4BIT            = 4'h2;
    localparam logic [12:0] WAIT_PULSE          = 13'(PULSE_US);
    localparam logic [12:0] WAIT_NONE           = 13'd0;

    typedef struct packed {
        logic        reg_sel;
        logic        enable;
        logic        read_write;
        logic [3:0]  data_nibble;
        logic [12:0] wait_us;
        logic        last;
    } t_snapshot;

    t_snapshot expected_snapshots[$];
    t_snapshot oldest;
    int        fail_count = 0;
    int        checked = 0;

    assign o_fail_count        = fail_count;
    assign o_snapshots_checked = checked;

    function automatic void add_snapshot(logic rs, logic e, logic [3:0] nib,
                                         logic [12:0] hold);
        t_snapshot s;
        s.reg_sel     = rs;
        s.enable      = e;
        s.read_write  = 1'b0;
        s.data_nibble = nib;
        s.wait_us     = hold;
        s.last        = 1'b0;
        expected_snapshots.push_back(s);
    endfunction

    function automatic void add_nibble(logic rs, logic [3:0] nib, logic [12:0] hold_after);
        add_snapshot(rs, 1'b0, nib, WAIT_NONE);
        add_snapshot(rs, 1'b1, nib, WAIT_PULSE);
        add_snapshot(rs, 1'b0, nib, hold_after);
    endfunction

    function automatic void add_byte(logic rs, logic [7:0] value);
        add_snapshot(rs, 1'b0, value[7:4], WAIT_NONE);
        add_snapshot(rs, 1'b1, value[7:4], WAIT_PULSE);
        add_snapshot(rs, 1'b0, value[3:0], WAIT_NONE);
        add_snapshot(rs, 1'b1, value[3:0], WAIT_PULSE);
        add_snapshot(rs, 1'b0, value[3:0], WAIT_NONE);
    endfunction

    function automatic void predict_request(t_op op, logic [7:0] ch, logic [5:0] col,
                                            logic row);
        logic [7:0] cursor;
        t_snapshot  tail;
        cursor = (row ? LINE2_BASE : LINE1_BASE) + {2'b00, col};
        case (op)
            OP_INIT: begin
                // The first step only drives RW low and lets the panel power up.
                add_snapshot(1'b0, 1'b0, 4'h0, WAIT_LONG);
                add_nibble(1'b0, NIB_WAKE, WAIT_LONG);
                add_nibble(1'b0, NIB_WAKE, WAIT_SHORT);
                add_nibble(1'b0, NIB_WAKE, WAIT_SHORT);
                add_nibble(1'b0, NIB_4BIT, WAIT_LONG);
                add_byte(1'b0, CMD_FUNC_4BIT_2LINE);
                add_byte(1'b0, CMD_DISPLAY_OFF);
                add_byte(1'b0, CMD_CLEAR);
                add_byte(1'b0, CMD_ENTRY_INCREMENT);
                add_byte(1'b0, CMD_DISPLAY_ON);
            end
            OP_CHAR:  add_byte(1'b1, ch);
            OP_CLEAR: add_byte(1'b0, CMD_CLEAR);
            default:  add_byte(1'b0, cursor);
        endcase
        tail = expected_snapshots.pop_back();
        tail.last = 1'b1;
        expected_snapshots.push_back(tail);
    endfunction

    function automatic void compare_field(string field, logic [12:0] want, logic [12:0] got);
        if (got !== want) begin
            $display("%0t ns: snapshot %0d %s expected %0h actual %0h",
                     $time, checked, field, want, got);
            fail_count++;
        end
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_pending <= 0;
        end else begin
            if (i_snap_valid && i_snap_ready) begin
                if (expected_snapshots.size() == 0) begin
                    $display("%0t ns: snapshot %0d expected none actual nibble %0h wait %0d",
                             $time, checked, i_data_nibble, i_wait_us);
                    fail_count++;
                end else begin
                    oldest = expected_snapshots.pop_front();
                    compare_field("reg_sel", oldest.reg_sel, i_reg_sel);
                    compare_field("enable", oldest.enable, i_enable);
                    compare_field("read_write", oldest.read_write, i_read_write);
                    compare_field("data_nibble", oldest.data_nibble, i_data_nibble);
                    compare_field("wait_us", oldest.wait_us, i_wait_us);
                    compare_field("last", oldest.last, i_last);
                end
                checked++;
            end
            if (i_req_valid && i_req_ready) begin
                predict_request(t_op'(i_op), i_char_code, i_column, i_row);
            end
            o_pending <= expected_snapshots.size();
        end
    end

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 100ps
// Testbench top for char_lcd_nibble_bus_sequencer: clock, reset, request stimulus and
// snapshot back-pressure, with lcd_snapshot_checker predicting and comparing beside the block.
// Depends on clnbs_pkg, the block and tb/lcd_snapshot_checker.sv.
module tb_top;
    import clnbs_pkg::*;

    localparam int unsigned PULSE_US        = 1;
    localparam int unsigned RANDOM_REQUESTS = 160;
    localparam int unsigned IDLE_LIMIT      = 2000;
    localparam int unsigned DRAIN_CYCLES    = 20;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic [1:0]  i_op = OP_INIT;
    logic [7:0]  i_char_code = 8'h00;
    logic [5:0]  i_column = 6'd0;
    logic        i_row = 1'b0;
    logic        i_out_ready = 1'b0;
    logic        o_in_ready;
    logic        o_out_valid;
    logic        o_reg_sel;
    logic        o_enable;
    logic        o_read_write;
    logic [3:0]  o_data_nibble;
    logic [12:0] o_wait_us;
    logic        o_last;

    int          snapshot_failures;
    int          snapshots_waiting;
    int          snapshots_checked;
    int          op_count [4] = '{0, 0, 0, 0};
    int unsigned sink_cycle = 0;
    int unsigned idle_cycles = 0;

    char_lcd_nibble_bus_sequencer #(
        .PULSE_US(PULSE_US)
    ) DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_op         (i_op),
        .i_char_code  (i_char_code),
        .i_column     (i_column),
        .i_row        (i_row),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_reg_sel    (o_reg_sel),
        .o_enable     (o_enable),
        .o_read_write (o_read_write),
        .o_data_nibble(o_data_nibble),
        .o_wait_us    (o_wait_us),
        .o_last       (o_last)
    );

    lcd_snapshot_checker #(
        .PULSE_US(PULSE_US)
    ) u_checker (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_req_valid        (i_in_valid),
        .i_req_ready        (o_in_ready),
        .i_op               (i_op),
        .i_char_code        (i_char_code),
        .i_column           (i_column),
        .i_row              (i_row),
        .i_snap_valid       (o_out_valid),
        .i_snap_ready       (i_out_ready),
        .i_reg_sel          (o_reg_sel),
        .i_enable           (o_enable),
        .i_read_write       (o_read_write),
        .i_data_nibble      (o_data_nibble),
        .i_wait_us          (o_wait_us),
        .i_last             (o_last),
        .o_fail_count       (snapshot_failures),
        .o_pending          (snapshots_waiting),
        .o_snapshots_checked(snapshots_checked)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // The sink cycles through always ready, even, sparse and mostly ready stretches.
    always @(posedge i_clk) begin
        sink_cycle <= sink_cycle + 1;
        case ((sink_cycle / 150) % 4)
            0:       i_out_ready <= 1'b1;
            1:       i_out_ready <= ($urandom_range(0, 1) == 1);
            2:       i_out_ready <= ($urandom_range(0, 3) == 0);
            default: i_out_ready <= ($urandom_range(0, 3) != 0);
        endcase
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles == IDLE_LIMIT) begin
            $display("%0t ns: nothing moved on either channel for %0d cycles", $time, IDLE_LIMIT);
            $display("FAILED: results differ");
            $finish;
        end
    end

    task automatic send_request(t_op op, logic [7:0] ch, logic [5:0] col, logic row);
        i_in_valid  <= 1'b1;
        i_op        <= op;
        i_char_code <= ch;
        i_column    <= col;
        i_row       <= row;
        op_count[int'(op)]++;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    task automatic send_random_request();
        int unsigned pick;
        t_op         op;
        pick = $urandom_range(0, 99);
        if (pick < 8) begin
            op = OP_INIT;
        end else if (pick < 55) begin
            op = OP_CHAR;
        end else if (pick < 70) begin
            op = OP_CLEAR;
        end else begin
            op = OP_GOTO;
        end
        send_request(op, 8'($urandom), 6'($urandom), 1'($urandom));
    endtask

    task automatic pause_sender(int unsigned cycles);
        i_in_valid <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    task automatic wait_for_drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (snapshots_waiting != 0) @(posedge i_clk);
    endtask

    initial begin
        int unsigned burst_left;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_request(OP_INIT, 8'h00, 6'd0, 1'b0);
        send_request(OP_CHAR, 8'h00, 6'd0, 1'b0);
        send_request(OP_CHAR, 8'hFF, 6'h3F, 1'b1);
        send_request(OP_CHAR, 8'hA5, 6'h2A, 1'b0);
        send_request(OP_CHAR, 8'h5A, 6'h15, 1'b1);
        send_request(OP_CLEAR, 8'hFF, 6'h3F, 1'b1);
        send_request(OP_CLEAR, 8'h00, 6'd0, 1'b0);
        send_request(OP_GOTO, 8'h00, 6'd0, 1'b0);
        send_request(OP_GOTO, 8'hFF, 6'h3F, 1'b0);
        send_request(OP_GOTO, 8'h00, 6'd0, 1'b1);
        // The second line base plus the widest column lands exactly on 0xFF.
        send_request(OP_GOTO, 8'h00, 6'h3F, 1'b1);
        send_request(OP_INIT, 8'hFF, 6'h3F, 1'b1);
        send_request(OP_CHAR, 8'h80, 6'h20, 1'b0);
        wait_for_drain();

        burst_left = $urandom_range(1, 12);
        for (int n = 0; n < RANDOM_REQUESTS; n++) begin
            send_random_request();
            burst_left = burst_left - 1;
            if (n == RANDOM_REQUESTS / 2) begin
                wait_for_drain();
            end else if (burst_left == 0) begin
                pause_sender($urandom_range(1, 8));
                burst_left = $urandom_range(1, 12);
            end
        end

        wait_for_drain();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("Run covered %0d requests: %0d init, %0d character, %0d clear, %0d cursor.",
                 op_count[0] + op_count[1] + op_count[2] + op_count[3],
                 op_count[int'(OP_INIT)], op_count[int'(OP_CHAR)],
                 op_count[int'(OP_CLEAR)], op_count[int'(OP_GOTO)]);
        $display("%0d pin snapshots were compared field by field under varying back-pressure.",
                 snapshots_checked);
        if (snapshot_failures == 0 && snapshots_waiting == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

// File: files.f
design/clnbs_pkg.sv
design/char_lcd_nibble_bus_sequencer.sv
tb/lcd_snapshot_checker.sv
tb/tb_top.sv
